@@ rtl/arp_cache_with_responder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Clocked, reset-qualified assertion helpers shared by the ARP cache RTL.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_RESPONDER_UNIT_DEFINES_SVH
`define ARP_CACHE_WITH_RESPONDER_UNIT_DEFINES_SVH

// implication checked at every rising clk edge outside reset
`define ARPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// property that must hold only while a result strobe is up
`define ARPC_ASSERT_ON_DONE(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) done |-> (prop)) \
		else $error(msg);

`endif

@@ rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared constants, operation codes and types of the ARP cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;

	localparam logic [1:0] OPER_TICK   = 2'd0;
	localparam logic [1:0] OPER_PACKET = 2'd1;
	localparam logic [1:0] OPER_LOOKUP = 2'd2;

	localparam logic [15:0] MIN_ARP_LEN = 16'd28;
	localparam logic [15:0] HW_ETHERNET = 16'd1;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'd1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] seen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic live;
		logic match;
	} eval_res_t;

endpackage

@@ rtl/arpc_ram.sv @@
// ----------------------------------------------------------------------------
// ARP cache RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/arpc_entry_eval.sv @@
// ----------------------------------------------------------------------------
// ARP cache entry evaluator
// Shared age/compare unit: decides whether one entry is live and matches.
// ----------------------------------------------------------------------------
module arpc_entry_eval (
	input  logic               valid,
	input  arpc_pkg::entry_t   ent,
	input  logic [31:0]        time_now,
	input  logic [31:0]        timeout,
	input  logic [31:0]        key,
	output arpc_pkg::eval_res_t res
);
	import arpc_pkg::*;

	logic [31:0] age;

	// modulo 2^32 age; zero timeout expires everything
	assign age       = time_now - ent.seen;
	assign res.live  = valid && (age < timeout);
	assign res.match = res.live && (ent.ip == key);

endmodule

@@ rtl/arp_cache_with_responder_unit.sv @@
// ----------------------------------------------------------------------------
// ARP cache with ageing and request responder
// Entry table in RAM, walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A tick, a valid
// Ethernet/IPv4 packet or a lookup walks the whole table through the entry
// RAM's single read port; the result follows the scan and the update state.
// A short or foreign packet and the unused operation code show an all-zero
// result in the cycle after acceptance, without a walk. Each
// result is shown for exactly one cycle with done high and the receiver
// cannot stall it, so it must be captured on that cycle. busy stays high
// during the walk; done comes in a cycle where busy is low, so a new
// transaction may be started in that same cycle.
`include "arp_cache_with_responder_unit_defines.svh"

module arp_cache_with_responder_unit #(
	parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] packet_length,
	input  logic [15:0] hardware_type,
	input  logic [15:0] protocol_type,
	input  logic [15:0] arp_opcode,
	input  logic [31:0] src_ip,
	input  logic [47:0] src_mac,
	input  logic [31:0] tgt_ip,
	input  logic [31:0] lookup_ip,
	output logic        done,
	output logic        reply_valid,
	output logic [47:0] reply_dest_mac,
	output logic [31:0] reply_target_ip,
	output logic        lookup_hit,
	output logic [47:0] lookup_mac,
	output logic        insert_dropped
);
	import arpc_pkg::*;

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

	state_t             state_q;
	logic [31:0]        own_ip_q;
	logic [31:0]        timeout_q;
	logic [31:0]        time_now_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               eval_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [1:0]         op_q;
	logic               found_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [47:0]        hit_mac_q;
	logic [31:0]        key_q;
	logic [47:0]        mac_q;
	logic               reply_q;

	logic               accept;
	logic               pkt_ok;
	logic               issue;
	logic               cfg_we;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_ent;
	eval_res_t          res;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pkt_ok = (packet_length >= MIN_ARP_LEN) && (hardware_type == HW_ETHERNET)
		&& (protocol_type == PROTO_IPV4);
	assign issue  = (state_q == ST_SCAN) && (cnt_q < CNT_W'(CACHE_ENTRIES));

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_q : own_ip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_OWN_IP:  own_ip_q  <= pwdata;
				REG_TIMEOUT: timeout_q <= pwdata;
				default: ;
			endcase
		end
	end

	// entry table
	assign ram_we    = (state_q == ST_UPDATE) && (op_q == OPER_PACKET)
		&& (found_q || free_found_q);
	assign ram_waddr = found_q ? hit_idx_q : free_idx_q;
	assign ram_wdata = '{ip: key_q, mac: mac_q, seen: time_now_q};
	assign rd_ent    = entry_t'(ram_rdata);

	arpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	arpc_entry_eval u_eval (
		.valid    (valid_q[idx_s1]),
		.ent      (rd_ent),
		.time_now (time_now_q),
		.timeout  (timeout_q),
		.key      (key_q),
		.res      (res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			valid_q         <= '0;
			time_now_q      <= '0;
			cnt_q           <= '0;
			eval_s1         <= 1'b0;
			op_q            <= OPER_TICK;
			found_q         <= 1'b0;
			free_found_q    <= 1'b0;
			done            <= 1'b0;
			reply_valid     <= 1'b0;
			reply_dest_mac  <= '0;
			reply_target_ip <= '0;
			lookup_hit      <= 1'b0;
			lookup_mac      <= '0;
			insert_dropped  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					eval_s1      <= 1'b0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					if (accept) begin
						op_q <= operation;
						priority if (operation == OPER_TICK) begin
							time_now_q <= time_now_q + 32'd1;
							state_q    <= ST_SCAN;
						end else if (operation == OPER_LOOKUP
							|| (operation == OPER_PACKET && pkt_ok)) begin
							state_q <= ST_SCAN;
						end else begin
							done            <= 1'b1;
							reply_valid     <= 1'b0;
							reply_dest_mac  <= '0;
							reply_target_ip <= '0;
							lookup_hit      <= 1'b0;
							lookup_mac      <= '0;
							insert_dropped  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					eval_s1 <= issue;
					if (eval_s1) begin
						if (!res.live) begin
							valid_q[idx_s1] <= 1'b0;
						end
						if (res.match && !found_q) begin
							found_q <= 1'b1;
						end
						if (!res.live && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					if (!issue && !eval_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					done            <= 1'b1;
					reply_valid     <= (op_q == OPER_PACKET) && reply_q;
					reply_dest_mac  <= ((op_q == OPER_PACKET) && reply_q) ? mac_q : '0;
					reply_target_ip <= ((op_q == OPER_PACKET) && reply_q) ? key_q : '0;
					lookup_hit      <= (op_q == OPER_LOOKUP) && found_q;
					lookup_mac      <= ((op_q == OPER_LOOKUP) && found_q) ? hit_mac_q : '0;
					insert_dropped  <= (op_q == OPER_PACKET) && !found_q && !free_found_q;
					if ((op_q == OPER_PACKET) && !found_q && free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload and scan captures
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= (operation == OPER_LOOKUP) ? lookup_ip : src_ip;
			mac_q   <= src_mac;
			reply_q <= (arp_opcode == OP_REQUEST) && (tgt_ip == own_ip_q);
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (eval_s1 && res.match && !found_q) begin
			hit_idx_q <= idx_s1;
			hit_mac_q <= rd_ent.mac;
		end
		if (eval_s1 && !res.live && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	`ARPC_ASSERT(a_update_then_done, (state_q == ST_UPDATE) |=> (done && !busy),
		"update state not followed by a result strobe")
	`ARPC_ASSERT_ON_DONE(a_reply_lookup_excl, !(reply_valid && lookup_hit),
		"reply and lookup hit in one result")
	`ARPC_ASSERT_ON_DONE(a_miss_zero_mac, lookup_hit || (lookup_mac == 48'd0),
		"lookup miss with nonzero MAC")
	`ARPC_ASSERT(a_ram_write_on_insert,
		ram_we |=> (done && !insert_dropped && (op_q == OPER_PACKET)),
		"entry write with dropped insert")

endmodule

@@ tb/tb_arp_cache_with_responder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache with responder testbench
// Drives ticks, ARP packets and lookups through the start/busy port, sets
// own IP and entry timeout over APB, and checks every done strobe against a
// cycle-free model of the cache table, ageing and reply logic.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_responder_unit;
	import arpc_pkg::*;

	localparam int         ENTRIES     = CACHE_ENTRIES_DEF;
	localparam int         LATENCY     = ENTRIES + 3;
	localparam logic [1:0] OPER_UNUSED = 2'd3;
	localparam logic [15:0] OP_REPLY   = 16'd2;
	localparam int         MAX_PRINTS  = 40;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] len;
		logic [15:0] hw;
		logic [15:0] proto;
		logic [15:0] opc;
		logic [31:0] sip;
		logic [47:0] smac;
		logic [31:0] tip;
		logic [31:0] lip;
	} arp_item_t;

	typedef struct packed {
		logic        reply_valid;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
		logic        hit;
		logic [47:0] hit_mac;
		logic        dropped;
	} arp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = OPER_TICK;
	logic [15:0] packet_length = '0;
	logic [15:0] hardware_type = '0;
	logic [15:0] protocol_type = '0;
	logic [15:0] arp_opcode = '0;
	logic [31:0] src_ip = '0;
	logic [47:0] src_mac = '0;
	logic [31:0] tgt_ip = '0;
	logic [31:0] lookup_ip = '0;
	logic        done;
	logic        reply_valid;
	logic [47:0] reply_dest_mac;
	logic [31:0] reply_target_ip;
	logic        lookup_hit;
	logic [47:0] lookup_mac;
	logic        insert_dropped;

	// model of the cache
	logic        tbl_live [ENTRIES];
	logic [31:0] tbl_ip   [ENTRIES];
	logic [47:0] tbl_mac  [ENTRIES];
	logic [31:0] tbl_seen [ENTRIES];
	logic [31:0] clock_ms;
	logic [31:0] own_ip_reg;
	logic [31:0] tmo_reg;

	arp_result_t expected_q[$];
	logic [31:0] ip_pool[32];

	int err_count = 0;
	int n_items = 0;
	int n_results = 0;
	int n_replies = 0;
	int n_hits = 0;
	int n_drops = 0;
	int burst_left = 0;

	arp_cache_with_responder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.operation(operation),
		.packet_length(packet_length),
		.hardware_type(hardware_type),
		.protocol_type(protocol_type),
		.arp_opcode(arp_opcode),
		.src_ip(src_ip),
		.src_mac(src_mac),
		.tgt_ip(tgt_ip),
		.lookup_ip(lookup_ip),
		.done(done),
		.reply_valid(reply_valid),
		.reply_dest_mac(reply_dest_mac),
		.reply_target_ip(reply_target_ip),
		.lookup_hit(lookup_hit),
		.lookup_mac(lookup_mac),
		.insert_dropped(insert_dropped)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("%0t: %s mismatch on result %0d: got %0h, expected %0h",
				$realtime, what, n_results, got, want);
	endtask

	always @(posedge clk) begin : result_check
		arp_result_t want;
		if (arst_n && done) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 64'd1, 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (reply_valid !== want.reply_valid)
					report_mismatch("reply_valid", 64'(reply_valid),
						64'(want.reply_valid));
				if (reply_dest_mac !== want.reply_mac)
					report_mismatch("reply_dest_mac", 64'(reply_dest_mac),
						64'(want.reply_mac));
				if (reply_target_ip !== want.reply_ip)
					report_mismatch("reply_target_ip", 64'(reply_target_ip),
						64'(want.reply_ip));
				if (lookup_hit !== want.hit)
					report_mismatch("lookup_hit", 64'(lookup_hit), 64'(want.hit));
				if (lookup_mac !== want.hit_mac)
					report_mismatch("lookup_mac", 64'(lookup_mac), 64'(want.hit_mac));
				if (insert_dropped !== want.dropped)
					report_mismatch("insert_dropped", 64'(insert_dropped),
						64'(want.dropped));
			end
		end
	end

	task automatic sweep_table();
		logic [31:0] age;
		for (int k = 0; k < ENTRIES; k++) begin
			age = clock_ms - tbl_seen[k];
			if (tbl_live[k] && age >= tmo_reg)
				tbl_live[k] = 1'b0;
		end
	endtask

	function automatic int find_entry(input logic [31:0] ip);
		for (int k = 0; k < ENTRIES; k++)
			if (tbl_live[k] && tbl_ip[k] == ip)
				return k;
		return -1;
	endfunction

	task automatic predict_arp(input arp_item_t it, output arp_result_t r);
		int idx;
		r = '0;
		case (it.op)
			OPER_TICK: begin
				clock_ms = clock_ms + 32'd1;
				sweep_table();
			end
			OPER_PACKET: begin
				if (it.len >= MIN_ARP_LEN && it.hw == HW_ETHERNET &&
						it.proto == PROTO_IPV4) begin
					sweep_table();
					idx = find_entry(it.sip);
					if (idx < 0) begin
						for (int k = ENTRIES - 1; k >= 0; k--)
							if (!tbl_live[k])
								idx = k;
						if (idx >= 0) begin
							tbl_live[idx] = 1'b1;
							tbl_ip[idx] = it.sip;
						end
					end
					if (idx < 0) begin
						r.dropped = 1'b1;
					end else begin
						tbl_mac[idx] = it.smac;
						tbl_seen[idx] = clock_ms;
					end
					if (it.opc == OP_REQUEST && it.tip == own_ip_reg) begin
						r.reply_valid = 1'b1;
						r.reply_mac = it.smac;
						r.reply_ip = it.sip;
					end
				end
			end
			OPER_LOOKUP: begin
				sweep_table();
				idx = find_entry(it.lip);
				if (idx >= 0) begin
					r.hit = 1'b1;
					r.hit_mac = tbl_mac[idx];
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [47:0] rand_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic arp_item_t noise_item();
		arp_item_t it;
		it.op = 2'($urandom_range(0, 2));
		it.len = 16'($urandom);
		it.hw = 16'($urandom);
		it.proto = 16'($urandom);
		it.opc = 16'($urandom);
		it.sip = $urandom;
		it.smac = rand_mac();
		it.tip = $urandom;
		it.lip = $urandom;
		return it;
	endfunction

	function automatic arp_item_t make_op(input logic [1:0] op);
		arp_item_t it;
		it = noise_item();
		it.op = op;
		return it;
	endfunction

	function automatic arp_item_t good_packet(input logic [15:0] opc,
			input logic [31:0] sip, input logic [47:0] smac, input logic [31:0] tip);
		arp_item_t it;
		it = make_op(OPER_PACKET);
		it.len = MIN_ARP_LEN;
		it.hw = HW_ETHERNET;
		it.proto = PROTO_IPV4;
		it.opc = opc;
		it.sip = sip;
		it.smac = smac;
		it.tip = tip;
		return it;
	endfunction

	function automatic arp_item_t lookup_of(input logic [31:0] ip);
		arp_item_t it;
		it = make_op(OPER_LOOKUP);
		it.lip = ip;
		return it;
	endfunction

	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0)
			burst_left = $urandom_range(20, 60);
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 25);
		return $urandom_range(30, 80);
	endfunction

	// called at a rising edge; returns at a rising edge
	task automatic send_item(input arp_item_t it);
		arp_result_t r;
		int gap;
		operation <= it.op;
		packet_length <= it.len;
		hardware_type <= it.hw;
		protocol_type <= it.proto;
		arp_opcode <= it.opc;
		src_ip <= it.sip;
		src_mac <= it.smac;
		tgt_ip <= it.tip;
		lookup_ip <= it.lip;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_arp(it, r);
		expected_q.push_back(r);
		n_items++;
		n_replies += int'(r.reply_valid);
		n_hits += int'(r.hit);
		n_drops += int'(r.dropped);
		gap = next_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (start)
			start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic read_reg_check(input logic idx);
		logic [31:0] got;
		logic [31:0] want;
		want = (idx == REG_OWN_IP) ? own_ip_reg : tmo_reg;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report_mismatch(idx == REG_OWN_IP ? "own_ip readback" : "timeout readback",
				64'(got), 64'(want));
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		wait_drained();
		repeat (LATENCY) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_OWN_IP)
			own_ip_reg = val;
		else
			tmo_reg = val;
		@(posedge clk);
		read_reg_check(idx);
	endtask

	task automatic test_register_reset();
		read_reg_check(REG_OWN_IP);
		@(posedge clk);
		read_reg_check(REG_TIMEOUT);
	endtask

	task automatic test_basic_ops();
		arp_item_t it;
		write_reg(REG_OWN_IP, 32'hC0A8_0101);
		write_reg(REG_TIMEOUT, 32'd5);
		send_item(make_op(OPER_TICK));
		send_item(make_op(OPER_UNUSED));
		// short and foreign packets
		it = good_packet(OP_REQUEST, 32'h0A00_0001, rand_mac(), own_ip_reg);
		it.len = MIN_ARP_LEN - 16'd1;
		send_item(it);
		it.len = 16'd0;
		send_item(it);
		it = good_packet(OP_REQUEST, 32'h0A00_0002, rand_mac(), own_ip_reg);
		it.hw = 16'd0;
		send_item(it);
		it.hw = 16'hFFFF;
		send_item(it);
		it.hw = HW_ETHERNET;
		it.proto = 16'h0000;
		send_item(it);
		it.proto = 16'hFFFF;
		send_item(it);
		// accepted packets
		send_item(good_packet(OP_REQUEST, 32'hFFFF_FFFF, {48{1'b1}}, own_ip_reg));
		it = good_packet(OP_REPLY, 32'h0000_0000, 48'h0, own_ip_reg);
		it.len = 16'hFFFF;
		send_item(it);
		send_item(good_packet(16'hFFFF, 32'h0A00_0003, rand_mac(), own_ip_reg));
		send_item(good_packet(16'h0000, 32'h0A00_0004, rand_mac(), own_ip_reg));
		send_item(good_packet(OP_REQUEST, 32'h0A00_0005, rand_mac(), 32'h0A00_0099));
		// known sender refresh
		send_item(good_packet(OP_REQUEST, 32'hFFFF_FFFF, 48'h0123_4567_89AB, own_ip_reg));
		send_item(lookup_of(32'hFFFF_FFFF));
		send_item(lookup_of(32'h0000_0000));
		send_item(lookup_of(32'h7F00_0001));
		repeat (6) send_item(make_op(OPER_TICK));
		send_item(lookup_of(32'hFFFF_FFFF));
	endtask

	task automatic test_full_table();
		write_reg(REG_OWN_IP, 32'h0000_0000);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		for (int k = 0; k < ENTRIES; k++)
			send_item(good_packet(OP_REPLY, 32'h0B00_0000 + k, rand_mac(), $urandom));
		// table full: dropped, but the reply still goes out
		send_item(good_packet(OP_REQUEST, 32'h0C00_0001, rand_mac(), 32'h0));
		send_item(good_packet(OP_REQUEST, 32'h0B00_0003, rand_mac(), 32'h0));
		send_item(lookup_of(32'h0B00_0003));
		send_item(lookup_of(32'h0B00_0000 + ENTRIES - 1));
		send_item(lookup_of(32'h0C00_0001));
	endtask

	task automatic test_zero_timeout();
		write_reg(REG_TIMEOUT, 32'd0);
		send_item(good_packet(OP_REQUEST, 32'h0D00_0001, rand_mac(), own_ip_reg));
		send_item(lookup_of(32'h0D00_0001));
		send_item(make_op(OPER_TICK));
		send_item(good_packet(OP_REPLY, 32'h0D00_0002, rand_mac(), own_ip_reg));
		send_item(lookup_of(32'h0B00_0003));
	endtask

	task automatic test_random(input int count, input logic [31:0] own,
			input logic [31:0] tmo, input int pool_n);
		arp_item_t it;
		int kind;
		write_reg(REG_OWN_IP, own);
		write_reg(REG_TIMEOUT, tmo);
		for (int k = 0; k < pool_n; k++)
			ip_pool[k] = $urandom;
		ip_pool[0] = own;
		ip_pool[1] = 32'h0000_0000;
		ip_pool[2] = 32'hFFFF_FFFF;
		for (int n = 0; n < count; n++) begin
			if (n % 128 == 127 && $urandom_range(0, 1) == 0)
				wait_drained();
			kind = $urandom_range(0, 99);
			if (kind < 28) begin
				it = make_op(OPER_TICK);
			end else if (kind < 85) begin
				it = good_packet($urandom_range(0, 99) < 55 ? OP_REQUEST :
					($urandom_range(0, 3) != 0 ? OP_REPLY : 16'($urandom)),
					ip_pool[$urandom_range(0, pool_n - 1)], rand_mac(),
					$urandom_range(0, 1) ? own : ip_pool[$urandom_range(0, pool_n - 1)]);
				if ($urandom_range(0, 3) == 0)
					it.len = 16'($urandom_range(MIN_ARP_LEN, 16'hFFFF));
				if (kind >= 65) begin
					it = lookup_of($urandom_range(0, 5) != 0 ?
						ip_pool[$urandom_range(0, pool_n - 1)] : $urandom);
				end
			end else if (kind < 95) begin
				it = good_packet(OP_REQUEST, ip_pool[$urandom_range(0, pool_n - 1)],
					rand_mac(), own);
				case ($urandom_range(0, 2))
					0: it.len = 16'($urandom_range(0, MIN_ARP_LEN - 1));
					1: it.hw = (16'($urandom) == HW_ETHERNET) ? 16'd0 : 16'($urandom) | 16'h2;
					default: it.proto = 16'($urandom) ^ PROTO_IPV4 | 16'h1;
				endcase
			end else begin
				it = noise_item();
			end
			send_item(it);
		end
	endtask

	initial begin
		for (int k = 0; k < ENTRIES; k++) begin
			tbl_live[k] = 1'b0;
			tbl_ip[k] = '0;
			tbl_mac[k] = '0;
			tbl_seen[k] = '0;
		end
		clock_ms = '0;
		own_ip_reg = '0;
		tmo_reg = TIMEOUT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_basic_ops();
		test_full_table();
		test_zero_timeout();
		test_random(350, $urandom, 32'd1, 20);
		test_random(350, $urandom, 32'd12, 24);
		test_random(300, 32'hFFFF_FFFF, 32'd60, 18);
		test_random(300, $urandom, TIMEOUT_RESET, 28);
		test_random(300, 32'h0000_0000, 32'hFFFF_FFFF, 20);

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		$display("%0d transactions, %0d results checked: %0d replies, %0d lookup hits, %0d drops",
			n_items, n_results, n_replies, n_hits, n_drops);
		$display("timeouts from 0 to max, ignored packets, refresh, full table and expiry");
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_entry_eval.sv
rtl/arp_cache_with_responder_unit.sv
tb/tb_arp_cache_with_responder_unit.sv
